### sv/nrvb_pkg.sv
// shared types and constants for the note record to byte stream converter
// no dependencies; imported by nrvb_ser and note_record_to_variable_bytes
package nrvb_pkg;

    localparam int NOTE_CAPACITY_DEF = 4096;

    // record type codes
    localparam logic [7:0] T_ENV1   = 8'd1;
    localparam logic [7:0] T_ENV2   = 8'd2;
    localparam logic [7:0] T_VOL    = 8'd3;
    localparam logic [7:0] T_MVOL   = 8'd4;
    localparam logic [7:0] T_KEYON  = 8'd5;
    localparam logic [7:0] T_KEYOFF = 8'd6;
    localparam logic [7:0] T_WAIT   = 8'd7;
    localparam logic [7:0] T_PDOWN  = 8'd8;
    localparam logic [7:0] T_JUMP   = 8'd9;
    localparam logic [7:0] T_LABEL  = 8'd10;

    // wait header bytes and their range limits
    localparam logic [7:0]  HDR_WAIT8  = 8'hB0;
    localparam logic [7:0]  HDR_WAIT16 = 8'hC0;
    localparam logic [7:0]  HDR_WAIT32 = 8'hD0;
    localparam logic [31:0] LIM_WAIT8  = 32'd256;
    localparam logic [31:0] LIM_WAIT16 = 32'd65536;

    // one record ready for byte serialization
    typedef struct packed {
        logic [7:0]  hdr;
        logic [31:0] payload;
        logic [2:0]  nbytes;
        logic [31:0] start_time;
        logic [31:0] loop_time;
        logic        err;
    } nrvb_rec_t;

endpackage

### sv/nrvb_ser.sv
// byte serializer: takes one encoded record, sends a byte per m_tready cycle
// depends on nrvb_pkg (nrvb_rec_t)
module nrvb_ser (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                load_valid,
    output logic                load_ready,
    input  nrvb_pkg::nrvb_rec_t load_rec,
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [71:0]         m_tdata,
    output logic                m_tlast,
    output logic [0:0]          m_tuser
);
    import nrvb_pkg::*;

    nrvb_rec_t   rec_reg;
    logic [2:0]  idx_reg;
    logic        busy_reg;
    logic [2:0]  idx_m1;
    logic [31:0] pay_sh;
    logic [7:0]  cur_byte;
    logic        done;

    assign idx_m1   = idx_reg - 3'd1;
    assign pay_sh   = rec_reg.payload >> {idx_m1, 3'b000};
    assign cur_byte = (idx_reg == 3'd0) ? rec_reg.hdr : pay_sh[7:0];
    assign m_tlast  = (idx_reg == rec_reg.nbytes - 3'd1);
    assign done     = busy_reg && m_tready && m_tlast;

    assign m_tvalid   = busy_reg;
    assign m_tdata    = {rec_reg.loop_time, rec_reg.start_time, cur_byte};
    assign m_tuser    = rec_reg.err;
    assign load_ready = !busy_reg || done;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            idx_reg  <= 3'd0;
        end else if (load_valid && load_ready) begin
            busy_reg <= 1'b1;
            idx_reg  <= 3'd0;
            rec_reg  <= load_rec;
        end else if (done) begin
            busy_reg <= 1'b0;
        end else if (busy_reg && m_tready) begin
            idx_reg <= idx_reg + 3'd1;
        end
    end

endmodule

### sv/note_record_to_variable_bytes.sv
// top level of the note record to variable-length byte stream converter
// depends on nrvb_pkg and nrvb_ser
//
// Takes one note record per request on the s_ side and sends 0 to 5 bytes of
// the variable-length encoding on the m_ side, one byte per cycle while
// m_tready is high, little-endian, with m_tlast on the last byte of each
// record. A record has 1 to 5 bytes (5 for a jump or a long wait), but a zero
// wait is taken at the input and sends nothing. The byte rate of the output
// channel sets the throughput; the first byte of a record passes through the
// stage register and the serializer's record register after its request is
// taken. The offset and time of each record are kept in one table memory of
// NOTE_CAPACITY 64-bit entries with a registered read; entries are written
// strictly in record order, so the record count tells which entries hold
// data and the table needs no clearing pass after reset. A jump to its own
// record is forwarded from the live counters. An invalid record type sends
// its header byte with m_tuser set and halts the block; every later record
// then gives one zero byte with m_tuser set, until reset.
module note_record_to_variable_bytes #(
    parameter int NOTE_CAPACITY = nrvb_pkg::NOTE_CAPACITY_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    // record input
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [55:0] s_tdata,  // note_op_a, note_op_b, note_op_c, note_value
    input  logic [7:0]  s_tuser,  // note_type
    // byte output
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [71:0] m_tdata,  // out_byte, start_time, loop_time
    output logic        m_tlast,  // last_byte
    output logic [0:0]  m_tuser   // error_flag
);
    import nrvb_pkg::*;

    localparam int          AW    = (NOTE_CAPACITY > 1) ? $clog2(NOTE_CAPACITY) : 1;
    localparam logic [31:0] CAP32 = 32'(NOTE_CAPACITY);

    // record fields
    logic [7:0]  typ, opa, opb, opc;
    logic [31:0] val;
    assign typ = s_tuser;
    assign opa = s_tdata[7:0];
    assign opb = s_tdata[15:8];
    assign opc = s_tdata[23:16];
    assign val = s_tdata[55:24];

    // running state
    logic [31:0] rc_reg, boff_reg, run_reg, loop_reg;
    logic        halted_reg;

    // table memory: {byte offset, start time} per record
    logic [63:0] tbl_mem [NOTE_CAPACITY];
    logic [63:0] rd_data_reg;

    // stage between table read and serializer
    logic        st_valid_reg;
    logic [7:0]  st_hdr_reg;
    logic [31:0] st_payload_reg;
    logic [2:0]  st_nb_reg;
    logic [31:0] st_t0_reg;
    logic        st_err_reg;
    logic        st_jump_reg;
    logic        st_jmem_reg;
    logic [31:0] st_jtime_reg;

    // decode of the incoming record
    logic [7:0]  hdr_next;
    logic [31:0] payload_next;
    logic [2:0]  nb_next;
    logic        err_next;
    logic        legal;
    logic        is_jump, jmem;
    logic [31:0] jtime_next;
    logic [31:0] dt;
    logic [31:0] rc_inc;
    logic        tgt_ok, tgt_self;

    logic        accept, st_move;
    logic        ser_ready;
    nrvb_rec_t   ser_rec;

    assign rc_inc   = rc_reg + 32'd1;
    // the current record's entry counts as written; a jump to it takes the live values
    assign tgt_ok   = (val < CAP32) && (val < rc_inc);
    assign tgt_self = (val == rc_reg);

    always_comb begin
        hdr_next     = {typ[3:0], opa[3:0]};
        payload_next = val;
        nb_next      = 3'd1;
        err_next     = 1'b0;
        legal        = 1'b1;
        is_jump      = 1'b0;
        jmem         = 1'b0;
        jtime_next   = 32'd0;
        dt           = 32'd0;
        if (halted_reg) begin
            hdr_next = 8'd0;
            err_next = 1'b1;
            legal    = 1'b0;
        end else begin
            case (typ)
                T_ENV1, T_ENV2, T_PDOWN: begin
                    payload_next = {16'd0, val[15:0]};
                    nb_next      = 3'd3;
                end
                T_VOL, T_MVOL: begin
                    payload_next = {24'd0, val[7:0]};
                    nb_next      = 3'd2;
                end
                T_KEYON: begin
                    payload_next = {16'd0, opc, opb};
                    nb_next      = 3'd3;
                end
                T_KEYOFF, T_LABEL: begin
                    nb_next = 3'd1;
                end
                T_WAIT: begin
                    dt = val;
                    if (val == 32'd0) begin
                        nb_next = 3'd0;
                    end else if (val < LIM_WAIT8) begin
                        hdr_next = HDR_WAIT8;
                        nb_next  = 3'd2;
                    end else if (val < LIM_WAIT16) begin
                        hdr_next = HDR_WAIT16;
                        nb_next  = 3'd3;
                    end else begin
                        hdr_next = HDR_WAIT32;
                        nb_next  = 3'd5;
                    end
                end
                T_JUMP: begin
                    is_jump = 1'b1;
                    nb_next = 3'd5;
                    if (!tgt_ok) begin
                        // never written or beyond the table: reads as zero
                        payload_next = 32'd0;
                    end else if (tgt_self) begin
                        // same entry is written this cycle: take the live values
                        payload_next = boff_reg;
                        jtime_next   = run_reg;
                    end else begin
                        jmem = 1'b1;
                    end
                end
                default: begin
                    err_next = 1'b1;
                    legal    = 1'b0;
                end
            endcase
        end
    end

    // a stage entry leaves when the serializer takes it or it has no bytes
    assign st_move  = st_valid_reg && ((st_nb_reg == 3'd0) || ser_ready);
    assign s_tready = !st_valid_reg || st_move;
    assign accept   = s_tvalid && s_tready;

    // table write and read
    always_ff @(posedge aclk) begin
        if (accept && legal && (rc_reg < CAP32)) begin
            tbl_mem[rc_reg[AW-1:0]] <= {boff_reg, run_reg};
        end
        if (accept && jmem) begin
            rd_data_reg <= tbl_mem[val[AW-1:0]];
        end
    end

    // counters, halt flag and loop time
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rc_reg     <= 32'd0;
            boff_reg   <= 32'd0;
            run_reg    <= 32'd0;
            loop_reg   <= 32'd0;
            halted_reg <= 1'b0;
        end else begin
            if (accept && legal) begin
                rc_reg   <= rc_inc;
                boff_reg <= boff_reg + {29'd0, nb_next};
                run_reg  <= run_reg + dt;
            end
            if (accept && err_next) begin
                halted_reg <= 1'b1;
            end
            // loop time follows jumps in record order as they leave the stage
            if (st_move && st_jump_reg) begin
                loop_reg <= st_jmem_reg ? rd_data_reg[31:0] : st_jtime_reg;
            end
        end
    end

    // stage register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_valid_reg <= 1'b0;
        end else if (accept) begin
            st_valid_reg <= 1'b1;
        end else if (st_move) begin
            st_valid_reg <= 1'b0;
        end
        if (accept) begin
            st_hdr_reg     <= hdr_next;
            st_payload_reg <= payload_next;
            st_nb_reg      <= nb_next;
            st_t0_reg      <= run_reg;
            st_err_reg     <= err_next;
            st_jump_reg    <= is_jump;
            st_jmem_reg    <= jmem;
            st_jtime_reg   <= jtime_next;
        end
    end

    // assemble the record for the serializer, table data arrives here
    always_comb begin
        ser_rec.hdr        = st_hdr_reg;
        ser_rec.payload    = (st_jump_reg && st_jmem_reg) ? rd_data_reg[63:32] : st_payload_reg;
        ser_rec.nbytes     = st_nb_reg;
        ser_rec.start_time = st_t0_reg;
        ser_rec.err        = st_err_reg;
        if (st_jump_reg) begin
            ser_rec.loop_time = st_jmem_reg ? rd_data_reg[31:0] : st_jtime_reg;
        end else begin
            ser_rec.loop_time = loop_reg;
        end
    end

    nrvb_ser u_ser (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .load_valid (st_valid_reg && (st_nb_reg != 3'd0)),
        .load_ready (ser_ready),
        .load_rec   (ser_rec),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tlast    (m_tlast),
        .m_tuser    (m_tuser)
    );

endmodule
